@@ design/packbits_row_decoder_assert.svh @@
// Assertion macros for the PackBits row decoder top level.
`ifndef PACKBITS_ROW_DECODER_ASSERT_SVH
`define PACKBITS_ROW_DECODER_ASSERT_SVH
`ifndef SYNTHESIS
`define PBRD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define PBRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBRD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define PBRD_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ design/pbrd_pkg.sv @@
// Shared types and constants of the PackBits row decoder.
package pbrd_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ROW_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED = 2'd2;

  localparam logic [15:0] ROW_WIDTH_RESET = 16'd320;
  localparam logic [15:0] ROW_COUNT_RESET = 16'd200;
  localparam logic COMPRESSED_RESET = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic consume;     // put one byte into the current row
    logic sel_rep;     // the byte comes from the held repeat byte
    logic load_lit;    // header starts a literal run
    logic load_rep;    // header starts a repeat run
    logic latch_byte;  // hold the repeat byte
    logic dec_lit;     // one literal byte used or skipped
    logic dec_rep;     // one repeat byte used
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;    // output register can take a group this cycle
    logic compressed;  // body is run-length coded
    logic hdr_repeat;  // incoming header byte starts a repeat
    logic row_end;     // the next consumed byte ends the row
    logic lit_one;     // one literal byte left
    logic rep_one;     // one repeat byte left
  } status_t;

endpackage

@@ design/pbrd_ctrl.sv @@
// Controller state machine of the PackBits row decoder.
module pbrd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pbrd_pkg::status_t status,
  output pbrd_pkg::cmd_t    cmd
);

  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_LITERAL = 3'd1;
  localparam logic [2:0] ST_REPEAT  = 3'd2;
  localparam logic [2:0] ST_SKIP    = 3'd3;
  localparam logic [2:0] ST_RUN     = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  always_comb begin
    case (state)
      ST_HEADER:  in_ready = status.compressed ? 1'b1 : status.out_free;
      ST_LITERAL: in_ready = status.out_free;
      ST_REPEAT:  in_ready = 1'b1;
      ST_SKIP:    in_ready = 1'b1;
      default:    in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_comb begin
    cmd = '0;
    state_next = state;
    case (state)
      ST_HEADER: begin
        if (accept) begin
          if (!status.compressed) begin
            cmd.consume = 1'b1;
          end else if (!status.hdr_repeat) begin
            cmd.load_lit = 1'b1;
            state_next = ST_LITERAL;
          end else begin
            cmd.load_rep = 1'b1;
            state_next = ST_REPEAT;
          end
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd.consume = 1'b1;
          cmd.dec_lit = 1'b1;
          // A literal run cut at the row end drops its remaining bytes.
          if (status.row_end && !status.lit_one) begin
            state_next = ST_SKIP;
          end else if (status.lit_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_REPEAT: begin
        if (accept) begin
          cmd.latch_byte = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_SKIP: begin
        if (accept) begin
          cmd.dec_lit = 1'b1;
          if (status.lit_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      ST_RUN: begin
        if (status.out_free) begin
          cmd.consume = 1'b1;
          cmd.sel_rep = 1'b1;
          cmd.dec_rep = 1'b1;
          if (status.row_end || status.rep_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ design/pbrd_datapath.sv @@
// Datapath of the PackBits row decoder: counters, pixel grouping and output register.
module pbrd_datapath (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [7:0]                         in_byte,
  input  pbrd_pkg::cmd_t                     cmd,
  output pbrd_pkg::status_t                  status,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic [31:0]                        out_pixels,
  output logic [2:0]                         out_count,
  output logic                               out_row_last,
  output logic                               out_image_last,
  output logic                               out_overrun
);

  logic [15:0] cfg_row_width;
  logic [15:0] cfg_row_count;
  logic        cfg_compressed;

  logic [7:0]  literal_left;
  logic [7:0]  rep_left;
  logic [7:0]  rep_byte;
  logic [16:0] row_bytes_left;
  logic [15:0] rows_left;
  logic        row_odd;
  logic        cut;
  logic [7:0]  group_buf [4];
  logic [2:0]  group_fill;

  logic [7:0]  cons_byte;
  logic        pad;
  logic [16:0] rbl_dec;
  logic        row_done;
  logic [7:0]  buf_new [4];
  logic [2:0]  fill_new;
  logic        emit_any;
  logic [31:0] pix_masked;
  logic [15:0] w_eff;
  logic [16:0] w_pad;
  logic [15:0] count_eff;
  logic [8:0]  lit_len;
  logic [8:0]  rep_len;
  logic        out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_row_width  <= pbrd_pkg::ROW_WIDTH_RESET;
      cfg_row_count  <= pbrd_pkg::ROW_COUNT_RESET;
      cfg_compressed <= pbrd_pkg::COMPRESSED_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        pbrd_pkg::CFG_ROW_WIDTH:  cfg_row_width  <= cfg_data;
        pbrd_pkg::CFG_ROW_COUNT:  cfg_row_count  <= cfg_data;
        pbrd_pkg::CFG_COMPRESSED: cfg_compressed <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid || out_ready;
  assign cons_byte = cmd.sel_rep ? rep_byte : in_byte;
  assign pad       = row_odd && (row_bytes_left == 17'd1);
  assign rbl_dec   = row_bytes_left - 17'd1;
  assign row_done  = (rbl_dec == 17'd0);

  always_comb begin
    buf_new  = group_buf;
    fill_new = group_fill;
    // The pad byte that makes a row even is counted but never stored.
    if (!pad) begin
      buf_new[group_fill[1:0]] = cons_byte;
      fill_new = group_fill + 3'd1;
    end
  end

  // A full group that holds the row's last pixel waits for the pad byte.
  assign emit_any = row_done || ((fill_new == 3'd4) && (rbl_dec != {16'd0, row_odd}));

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pix_masked[i*8 +: 8] = (3'(i) < fill_new) ? buf_new[i] : 8'd0;
    end
  end

  assign w_eff     = (cfg_row_width == 16'd0) ? 16'd1 : cfg_row_width;
  assign w_pad     = {1'b0, w_eff} + {16'd0, w_eff[0]};
  assign count_eff = (cfg_row_count == 16'd0) ? 16'd1 : cfg_row_count;
  assign lit_len   = {2'd0, in_byte[6:0]} + 9'd1;
  assign rep_len   = 9'd257 - {1'b0, in_byte};

  always_ff @(posedge clk) begin
    if (rst) begin
      literal_left   <= 8'd0;
      rep_left       <= 8'd0;
      row_bytes_left <= {1'b0, pbrd_pkg::ROW_WIDTH_RESET} + {16'd0, pbrd_pkg::ROW_WIDTH_RESET[0]};
      row_odd        <= pbrd_pkg::ROW_WIDTH_RESET[0];
      rows_left      <= pbrd_pkg::ROW_COUNT_RESET;
      cut            <= 1'b0;
      group_fill     <= 3'd0;
    end else begin
      if (cmd.load_lit) begin
        literal_left <= lit_len[7:0];
        cut          <= {8'd0, lit_len} > row_bytes_left;
      end else if (cmd.dec_lit && (literal_left != 8'd0)) begin
        literal_left <= literal_left - 8'd1;
      end
      if (cmd.load_rep) begin
        rep_left <= rep_len[7:0];
        cut      <= {8'd0, rep_len} > row_bytes_left;
      end else if (cmd.dec_rep) begin
        rep_left <= rep_left - 8'd1;
      end
      if (cmd.consume) begin
        if (row_done) begin
          rows_left      <= (rows_left == 16'd1) ? count_eff : rows_left - 16'd1;
          row_bytes_left <= w_pad;
          row_odd        <= w_eff[0];
          cut            <= 1'b0;
          group_fill     <= 3'd0;
        end else begin
          row_bytes_left <= rbl_dec;
          group_fill     <= emit_any ? 3'd0 : fill_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_byte) begin
      rep_byte <= in_byte;
    end
    if (cmd.consume) begin
      group_buf <= buf_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.consume && emit_any) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.consume && emit_any) begin
      out_pixels     <= pix_masked;
      out_count      <= fill_new;
      out_row_last   <= row_done;
      out_image_last <= row_done && (rows_left == 16'd1);
      out_overrun    <= row_done && cut;
    end
  end

  always_comb begin
    status.out_free   = out_free;
    status.compressed = cfg_compressed;
    status.hdr_repeat = in_byte[7];
    status.row_end    = (row_bytes_left == 17'd1);
    status.lit_one    = (literal_left == 8'd1);
    status.rep_one    = (rep_left == 8'd1);
  end

endmodule

@@ design/packbits_row_decoder.sv @@
// Top level of the PackBits row decoder.
// Takes body bytes one item at a time and delivers decoded pixels in groups of up to
// four, with tlast on the group that ends a row. Raw bytes and literal bytes are taken
// at one per cycle while the output register is free or being emptied. A repeat run
// plays out as header, data byte, then one pixel a cycle from the repeat counter while
// the output register is free, ending early when the run is cut at the row end,
// and input is held off while it plays out. The single output register holds one group;
// while it waits to be taken, pixel production stops. The pad byte of an odd row is
// taken but not delivered. Register writes go straight in; row_width takes effect at
// the next row, row_count at the next image, compressed at the next header.
module packbits_row_decoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [pbrd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbrd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // stream_byte
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [39:0]                     m_tdata,   // pixel_a, pixel_b, pixel_c, pixel_d,
                                                     // valid_count, zero fill
  output logic                            m_tlast,   // row_last
  output logic [1:0]                      m_tuser    // image_last, overrun
);

  pbrd_pkg::cmd_t    cmd;
  pbrd_pkg::status_t status;
  logic [31:0]       out_pixels;
  logic [2:0]        out_count;
  logic              out_image_last;
  logic              out_overrun;

  pbrd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pbrd_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_byte        (s_tdata),
    .cmd            (cmd),
    .status         (status),
    .out_ready      (m_tready),
    .out_valid      (m_tvalid),
    .out_pixels     (out_pixels),
    .out_count      (out_count),
    .out_row_last   (m_tlast),
    .out_image_last (out_image_last),
    .out_overrun    (out_overrun)
  );

  assign m_tdata = {5'd0, out_count, out_pixels};
  assign m_tuser = {out_overrun, out_image_last};

`include "packbits_row_decoder_assert.svh"

  `PBRD_ASSERT_IMPLY(a_consume_free, clk, rst, cmd.consume, status.out_free, "pixel taken while output register is full")
  `PBRD_ASSERT_IMPLY(a_count_range, clk, rst, m_tvalid, (m_tdata[34:32] != 3'd0) && (m_tdata[34:32] <= 3'd4), "group pixel count out of range")
  `PBRD_ASSERT_IMPLY(a_flags_on_row_end, clk, rst, m_tvalid && (m_tuser[0] || m_tuser[1]), m_tlast, "image end or overrun on a group that does not end a row")
  `PBRD_ASSERT_NEXT(a_row_end_group, clk, rst, cmd.consume && status.row_end, m_tvalid && m_tlast, "row end without a row-ending group")

endmodule
